/* sv/sps_pkg.sv */
// Shared types and constants for the servo PWM slew generator.
`default_nettype none

package sps_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MIN_ANGLE    = 3'd0;
    localparam logic [2:0] REG_MAX_ANGLE    = 3'd1;
    localparam logic [2:0] REG_MIN_PULSE    = 3'd2;
    localparam logic [2:0] REG_MAX_PULSE    = 3'd3;
    localparam logic [2:0] REG_PERIOD_TICKS = 3'd4;
    localparam logic [2:0] REG_RAMP_STEP    = 3'd5;

    // Configuration reset values
    localparam logic [7:0]  RST_MIN_ANGLE    = 8'd0;
    localparam logic [7:0]  RST_MAX_ANGLE    = 8'd180;
    localparam logic [15:0] RST_MIN_PULSE    = 16'd500;
    localparam logic [15:0] RST_MAX_PULSE    = 16'd2500;
    localparam logic [15:0] RST_PERIOD_TICKS = 16'd20000;
    localparam logic [7:0]  RST_RAMP_STEP    = 8'd5;

    // State reset values
    localparam logic [15:0] RST_PULSE_WIDTH  = 16'd1500;
    localparam logic [7:0]  RST_STORED_ANGLE = 8'd90;

    // Angle span times pulse span fits 24 bits; one quotient bit per cycle
    localparam int DIV_STEPS   = 24;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic clamp;
        logic mul;
        logic div_step;
        logic map;
        logic tick;
        logic ramp;
        logic out_load;
    } sps_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic span_ok;
        logic ramp_due;
    } sps_stat_t;

endpackage

`default_nettype wire

/* sv/sps_ctrl.sv */
// Sequencing state machine: input/output handshakes and per-word step order.
`default_nettype none

module sps_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_operation,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sps_pkg::sps_cmd_t     cmd,
    input  wire sps_pkg::sps_stat_t stat
);
    import sps_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MAP   = 3'd4;
    localparam logic [2:0] ST_TICK  = 3'd5;
    localparam logic [2:0] ST_RAMP  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Decode state into datapath commands and pick the next state
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = s_operation ? ST_CLAMP : ST_TICK;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = stat.span_ok ? ST_MUL : ST_MAP;
            end
            ST_MUL: begin
                cmd.mul      = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                cmd.map    = 1'b1;
                state_next = ST_DONE;
            end
            ST_TICK: begin
                cmd.tick   = 1'b1;
                state_next = stat.ramp_due ? ST_RAMP : ST_DONE;
            end
            ST_RAMP: begin
                cmd.ramp   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until the sink takes it
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* sv/sps_dp.sv */
// Datapath: configuration, angle mapping with serial divider, PWM counter and ramp.
`default_nettype none

module sps_dp #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sps_pkg::sps_cmd_t  cmd,
    output sps_pkg::sps_stat_t      stat,
    input  wire logic               s_operation,
    input  wire logic [7:0]         s_angle,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    m_pin_level,
    output logic [7:0]              m_angle_now,
    output logic [15:0]             m_pulse_now
);
    import sps_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    // Configuration
    logic [7:0]  min_angle_reg, max_angle_reg, ramp_step_reg;
    logic [15:0] min_pulse_reg, max_pulse_reg, period_ticks_reg;

    // Item and state
    logic [7:0]             angle_in_reg;
    logic                   pin_reg, pin_next;
    logic [7:0]             stored_angle_reg, stored_angle_next;
    logic [7:0]             off_reg, off_next;
    logic                   neg_reg, neg_next;
    logic [23:0]            quo_reg, quo_next;
    logic [7:0]             rem_reg, rem_next;
    logic [15:0]            target_reg, target_next;
    logic [15:0]            pulse_reg, pulse_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic                   low_reg, low_next;

    // Output word
    logic        out_pin_reg;
    logic [7:0]  out_angle_reg;
    logic [15:0] out_pulse_reg;

    logic [7:0]             clamp_hi, clamp_a, span_a;
    logic [15:0]            span_p_mag, low_len, diff, step16, delta;
    logic [8:0]             trial;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   hi_end, lo_end;

    assign span_a        = max_angle_reg - min_angle_reg;
    assign stat.span_ok  = (max_angle_reg > min_angle_reg);

    // Clamp to max first, then raise to min
    assign clamp_hi = (angle_in_reg > max_angle_reg) ? max_angle_reg : angle_in_reg;
    assign clamp_a  = (clamp_hi < min_angle_reg) ? min_angle_reg : clamp_hi;

    // Pulse span as sign and magnitude so the quotient truncates toward zero
    assign span_p_mag = (max_pulse_reg < min_pulse_reg) ? (min_pulse_reg - max_pulse_reg)
                                                        : (max_pulse_reg - min_pulse_reg);

    // Restoring divide step
    assign trial = {rem_reg, quo_reg[23]};

    // PWM phase ends
    assign tick_inc = tick_reg + 1'b1;
    assign low_len  = (period_ticks_reg > pulse_reg) ? (period_ticks_reg - pulse_reg) : 16'd1;
    assign hi_end   = (CMP_W'(tick_inc) >= CMP_W'(pulse_reg));
    assign lo_end   = (CMP_W'(tick_inc) >= CMP_W'(low_len));
    assign stat.ramp_due = low_reg && lo_end;

    // Ramp step limited to the remaining distance
    assign diff   = (pulse_reg < target_reg) ? (target_reg - pulse_reg)
                                             : (pulse_reg - target_reg);
    assign step16 = 16'(ramp_step_reg);
    assign delta  = (step16 < diff) ? step16 : diff;

    always_comb begin
        pin_next          = pin_reg;
        stored_angle_next = stored_angle_reg;
        off_next          = off_reg;
        neg_next          = neg_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        target_next       = target_reg;
        pulse_next        = pulse_reg;
        tick_next         = tick_reg;
        low_next          = low_reg;

        // Set-angle words report a low pin
        if (cmd.load_in) begin
            pin_next = 1'b0;
        end
        if (cmd.clamp) begin
            stored_angle_next = clamp_a;
            off_next          = clamp_a - min_angle_reg;
            neg_next          = (max_pulse_reg < min_pulse_reg);
        end
        // Offset times pulse span, then shift through the divider
        if (cmd.mul) begin
            quo_next = 24'(off_reg) * 24'(span_p_mag);
            rem_next = '0;
        end
        if (cmd.div_step) begin
            if (trial >= {1'b0, span_a}) begin
                rem_next = 8'(trial - {1'b0, span_a});
                quo_next = {quo_reg[22:0], 1'b1};
            end else begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[22:0], 1'b0};
            end
        end
        // Quotient magnitude never exceeds the pulse span, so the sum stays in range
        if (cmd.map) begin
            if (!stat.span_ok) begin
                target_next = min_pulse_reg;
            end else if (neg_reg) begin
                target_next = min_pulse_reg - quo_reg[15:0];
            end else begin
                target_next = min_pulse_reg + quo_reg[15:0];
            end
        end
        // Advance the period counter
        if (cmd.tick) begin
            tick_next = tick_inc;
            if (!low_reg) begin
                pin_next = 1'b1;
                if (hi_end) begin
                    tick_next = '0;
                    low_next  = 1'b1;
                end
            end else begin
                pin_next = 1'b0;
                if (lo_end) begin
                    tick_next = '0;
                    low_next  = 1'b0;
                end
            end
        end
        if (cmd.ramp) begin
            if (pulse_reg < target_reg) begin
                pulse_next = pulse_reg + delta;
            end else if (pulse_reg > target_reg) begin
                pulse_next = pulse_reg - delta;
            end
        end
    end

    // Configuration and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg    <= RST_MIN_ANGLE;
            max_angle_reg    <= RST_MAX_ANGLE;
            min_pulse_reg    <= RST_MIN_PULSE;
            max_pulse_reg    <= RST_MAX_PULSE;
            period_ticks_reg <= RST_PERIOD_TICKS;
            ramp_step_reg    <= RST_RAMP_STEP;
            stored_angle_reg <= RST_STORED_ANGLE;
            target_reg       <= RST_PULSE_WIDTH;
            pulse_reg        <= RST_PULSE_WIDTH;
            tick_reg         <= '0;
            low_reg          <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MIN_ANGLE:    min_angle_reg    <= cfg_data[7:0];
                    REG_MAX_ANGLE:    max_angle_reg    <= cfg_data[7:0];
                    REG_MIN_PULSE:    min_pulse_reg    <= cfg_data;
                    REG_MAX_PULSE:    max_pulse_reg    <= cfg_data;
                    REG_PERIOD_TICKS: period_ticks_reg <= cfg_data;
                    REG_RAMP_STEP:    ramp_step_reg    <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            stored_angle_reg <= stored_angle_next;
            target_reg       <= target_next;
            pulse_reg        <= pulse_next;
            tick_reg         <= tick_next;
            low_reg          <= low_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            angle_in_reg <= s_operation ? s_angle : angle_in_reg;
        end
        pin_reg <= pin_next;
        off_reg <= off_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.out_load) begin
            out_pin_reg   <= pin_reg;
            out_angle_reg <= stored_angle_reg;
            out_pulse_reg <= pulse_reg;
        end
    end

    assign m_pin_level = out_pin_reg;
    assign m_angle_now = out_angle_reg;
    assign m_pulse_now = out_pulse_reg;

endmodule

`default_nettype wire

/* sv/servo_pwm_slew_generator_core.sv */
// Top level of the servo PWM generator with slew-limited pulse width.
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_operation, s_angle
//  m_        out        m_valid / m_ready      m_pin_level, m_angle_now, m_pulse_now
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick word runs the tick state, then the ramp state when the period ends and the
// width ramps; a set-angle word runs clamp, multiply, the one-bit-per-cycle 24-step
// divider and map (clamp goes straight to map when the angle range is empty and no
// divide runs). One word is in work at a time; the next is taken once the result is
// loaded into the output register. A stalled sink holds the finished word in the
// last state. Synchronous active-low reset restores control, configuration and PWM
// state registers to defaults, not payload ones; config writes are always taken.
`default_nettype none

module servo_pwm_slew_generator_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_angle,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_pin_level,
    output logic [7:0]       m_angle_now,
    output logic [15:0]      m_pulse_now,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import sps_pkg::*;

    sps_cmd_t  cmd;
    sps_stat_t stat;

    assign cfg_ready = 1'b1;

    sps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    sps_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_operation (s_operation),
        .s_angle     (s_angle),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_pin_level (m_pin_level),
        .m_angle_now (m_angle_now),
        .m_pulse_now (m_pulse_now)
    );

`ifndef SYNTHESIS
    // One word in work: an accepted word blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready while a word is in work");

    // A new result only appears while the input side is busy
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load) |-> !s_ready)
        else $error("result loaded while idle");

    // A ramp command only follows a tick command
    a_ramp_after_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ramp |-> $past(cmd.tick))
        else $error("ramp without a preceding tick");
`endif

endmodule

`default_nettype wire

/* tb/tb_servo_pwm_slew_generator_core.sv */
// Self-checking testbench for the servo PWM slew generator core.
`default_nettype none

module tb_servo_pwm_slew_generator_core;
    import sps_pkg::*;

    localparam int COUNT_W = 16;
    localparam int CYCLE_LIMIT = 1000000;

    // Word operations
    localparam logic OP_TICK      = 1'b0;
    localparam logic OP_SET_ANGLE = 1'b1;

    // Register indexes that select nothing
    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;

    typedef struct packed {
        logic        pin;
        logic [7:0]  angle;
        logic [15:0] pulse;
    } pwm_word_t;

    // Tracks registers and PWM state, predicts one output word per input word
    class servo_pwm_tracker;
        logic [7:0]         lo_angle;
        logic [7:0]         hi_angle;
        logic [15:0]        lo_pulse;
        logic [15:0]        hi_pulse;
        logic [15:0]        period;
        logic [7:0]         step;
        logic [COUNT_W-1:0] ticks;
        logic               in_low;
        logic [15:0]        width;
        logic [15:0]        target;
        logic [7:0]         angle;
        pwm_word_t          words_due[$];
        int                 mismatches;

        function new();
            lo_angle   = RST_MIN_ANGLE;
            hi_angle   = RST_MAX_ANGLE;
            lo_pulse   = RST_MIN_PULSE;
            hi_pulse   = RST_MAX_PULSE;
            period     = RST_PERIOD_TICKS;
            step       = RST_RAMP_STEP;
            ticks      = '0;
            in_low     = 1'b0;
            width      = RST_PULSE_WIDTH;
            target     = RST_PULSE_WIDTH;
            angle      = RST_STORED_ANGLE;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_MIN_ANGLE:    lo_angle = data[7:0];
                REG_MAX_ANGLE:    hi_angle = data[7:0];
                REG_MIN_PULSE:    lo_pulse = data;
                REG_MAX_PULSE:    hi_pulse = data;
                REG_PERIOD_TICKS: period   = data;
                REG_RAMP_STEP:    step     = data[7:0];
                default: ;
            endcase
        endfunction

        // Map a clamped angle onto the pulse range, truncating toward zero
        function logic [15:0] angle_to_pulse(logic [7:0] a);
            longint span_a;
            longint span_p;
            longint off;
            longint base;
            longint t;
            span_a = hi_angle;
            span_a = span_a - lo_angle;
            span_p = hi_pulse;
            span_p = span_p - lo_pulse;
            base   = lo_pulse;
            if (span_a <= 0) begin
                return lo_pulse;
            end
            off = a;
            off = off - lo_angle;
            t = base + (off * span_p) / span_a;
            if (t < 0) t = 0;
            if (t > 65535) t = 65535;
            return t[15:0];
        endfunction

        // Move the width toward the target, never past it
        function void ramp_width();
            logic [15:0] d;
            if (width < target) begin
                d = target - width;
                width = width + (({8'd0, step} < d) ? {8'd0, step} : d);
            end else if (width > target) begin
                d = width - target;
                width = width - (({8'd0, step} < d) ? {8'd0, step} : d);
            end
        endfunction

        function void take_word(logic op, logic [7:0] req);
            pwm_word_t   w;
            logic [7:0]  a;
            logic [15:0] low_len;
            w.pin = 1'b0;
            if (op == OP_SET_ANGLE) begin
                a = req;
                if (a > hi_angle) a = hi_angle;
                if (a < lo_angle) a = lo_angle;
                angle  = a;
                target = angle_to_pulse(a);
            end else begin
                ticks = ticks + 1'b1;
                if (!in_low) begin
                    w.pin = 1'b1;
                    if (ticks >= width) begin
                        ticks  = '0;
                        in_low = 1'b1;
                    end
                end else begin
                    low_len = (period > width) ? period - width : 16'd1;
                    if (ticks >= low_len) begin
                        ticks  = '0;
                        in_low = 1'b0;
                        ramp_width();
                    end
                end
            end
            w.angle = angle;
            w.pulse = width;
            words_due.push_back(w);
        endfunction

        function void match_word(logic pin, logic [7:0] ang, logic [15:0] pulse);
            pwm_word_t w;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: pin %0b angle %0d pulse %0d",
                             pin, ang, pulse);
                return;
            end
            w = words_due.pop_front();
            if (w.pin !== pin || w.angle !== ang || w.pulse !== pulse) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("exp pin %0b ang %0d pulse %0d / got pin %0b ang %0d pulse %0d",
                             w.pin, w.angle, w.pulse, pin, ang, pulse);
            end
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_TICK;
    logic [7:0]  s_angle   = 8'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_pin_level;
    logic [7:0]  m_angle_now;
    logic [15:0] m_pulse_now;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_MIN_ANGLE;
    logic [15:0] cfg_data  = 16'd0;

    servo_pwm_tracker tracker = new();

    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic sink_hold      = 1'b0;
    int   cycle_count    = 0;

    servo_pwm_slew_generator_core #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_angle     (s_angle),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pin_level (m_pin_level),
        .m_angle_now (m_angle_now),
        .m_pulse_now (m_pulse_now),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Check each accepted output word, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_word(m_pin_level, m_angle_now, m_pulse_now);
        if (sink_hold)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input logic op, input logic [7:0] ang);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_angle     <= ang;
        do @(posedge aclk); while (!s_ready);
        tracker.take_word(op, ang);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Write all registers; 8-bit ones get junk in the upper byte
    task automatic load_setting(input logic [7:0] la, input logic [7:0] ha,
                                input logic [15:0] lp, input logic [15:0] hp,
                                input logic [15:0] per, input logic [7:0] st);
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B,
                  16'($urandom_range(65535)));
        write_reg(REG_MIN_ANGLE, {junk, la});
        write_reg(REG_MAX_ANGLE, {~junk, ha});
        write_reg(REG_MIN_PULSE, lp);
        write_reg(REG_MAX_PULSE, hp);
        write_reg(REG_PERIOD_TICKS, per);
        write_reg(REG_RAMP_STEP, {junk ^ 8'h5a, st});
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.words_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_idling(input int src, input int sink);
        src_idle_pct = src;
        sink_stall_pct <= sink;
    endtask

    task automatic random_words(input int count, input int tick_pct);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < tick_pct)
                send_word(OP_TICK, 8'($urandom_range(255)));
            else
                send_word(OP_SET_ANGLE, 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int ph;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: range ends, clamp above max, ticks
        send_word(OP_SET_ANGLE, 8'd0);
        send_word(OP_SET_ANGLE, 8'd255);
        send_word(OP_SET_ANGLE, 8'd90);
        send_word(OP_TICK, 8'd0);
        send_word(OP_TICK, 8'd255);
        send_word(OP_SET_ANGLE, 8'd181);

        // Falling mapping, clamp on both sides
        settle();
        load_setting(8'd30, 8'd200, 16'd3000, 16'd100, 16'd20000, 8'd5);
        send_word(OP_SET_ANGLE, 8'd29);
        send_word(OP_SET_ANGLE, 8'd31);
        send_word(OP_SET_ANGLE, 8'd115);
        send_word(OP_SET_ANGLE, 8'd200);
        send_word(OP_SET_ANGLE, 8'd255);
        send_word(OP_TICK, 8'd170);

        // Empty angle range at the top end
        settle();
        load_setting(8'd255, 8'd255, 16'd7, 16'd9, 16'd20000, 8'd5);
        send_word(OP_SET_ANGLE, 8'd0);
        send_word(OP_SET_ANGLE, 8'd255);

        // Min angle above max angle
        settle();
        load_setting(8'd200, 8'd50, 16'd0, 16'd65535, 16'd20000, 8'd5);
        send_word(OP_SET_ANGLE, 8'd10);
        send_word(OP_SET_ANGLE, 8'd120);

        // Ramp onto a nearby target with a period shorter than the pulse;
        // the step is cut to the remaining distance
        settle();
        load_setting(8'd0, 8'd255, 16'd1400, 16'd1440, 16'd16, 8'd255);
        send_word(OP_SET_ANGLE, 8'd0);
        while (tracker.width == RST_PULSE_WIDTH)
            send_word(OP_TICK, 8'($urandom_range(255)));
        random_words(40, 100);

        // Random phases with rotating idle patterns
        for (ph = 0; ph < 9; ph++) begin
            settle();
            case (ph)
                7: load_setting(8'd0, 8'd255, 16'd65535, 16'd0, 16'd1, 8'd255);
                8: load_setting(8'd0, 8'd255, 16'd0, 16'd65535, 16'd65535, 8'd255);
                default: load_setting(8'($urandom_range(100)), 8'($urandom_range(255)),
                                      16'($urandom_range(48)), 16'($urandom_range(48)),
                                      16'($urandom_range(64)), 8'($urandom_range(8)));
            endcase
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(66, 0);
                2: set_idling(0, 66);
                default: set_idling(7, 7);
            endcase
            // Hold the sink off so the core backs up its input
            if (ph == 0) begin
                fork
                    begin
                        sink_hold <= 1'b1;
                        repeat (300) @(posedge aclk);
                        sink_hold <= 1'b0;
                    end
                join_none
            end
            random_words(16, 85);
        end

        settle();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.words_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
sv/sps_pkg.sv
sv/sps_ctrl.sv
sv/sps_dp.sv
sv/servo_pwm_slew_generator_core.sv
tb/tb_servo_pwm_slew_generator_core.sv
